// ===== rtl/glfs_pkg.sv =====
// Shared widths, command codes and tile classification for the line scan block.
package glfs_pkg;

    localparam int COMMAND_W    = 1;
    localparam int TILE_COL_W   = 8;
    localparam int TILE_ROW_W   = 7;
    localparam int TILE_VALUE_W = 8;
    localparam int START_X_W    = 28;
    localparam int START_Y_W    = 27;
    localparam int HIT_TILE_W   = 8;
    localparam int HIT_X_W      = 12;
    localparam int HIT_Y_W      = 11;

    localparam logic [COMMAND_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [COMMAND_W-1:0] CMD_SCAN  = 1'b1;

    localparam logic [TILE_VALUE_W-1:0] SOLID_CODE_A = 8'd1;
    localparam logic [TILE_VALUE_W-1:0] SOLID_CODE_B = 8'd2;
    localparam logic [TILE_VALUE_W-1:0] SOLID_CODE_C = 8'd5;

    function automatic logic is_solid(input logic [TILE_VALUE_W-1:0] code);
        return (code == SOLID_CODE_A) || (code == SOLID_CODE_B) || (code == SOLID_CODE_C);
    endfunction

endpackage

// ===== rtl/glfs_in_if.sv =====
// Request channel: tile writes and line scans.
interface glfs_in_if;
    import glfs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COMMAND_W-1:0]    command;
    logic [TILE_COL_W-1:0]   tile_col;
    logic [TILE_ROW_W-1:0]   tile_row;
    logic [TILE_VALUE_W-1:0] tile_value;
    logic [START_X_W-1:0]    start_x;
    logic [START_Y_W-1:0]    start_y;
    logic [START_X_W-1:0]    end_x;
    logic [START_Y_W-1:0]    end_y;

    modport source (
        output valid, command, tile_col, tile_row, tile_value,
               start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, command, tile_col, tile_row, tile_value,
               start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

// ===== rtl/glfs_out_if.sv =====
// Result channel: one scan outcome per scan request.
interface glfs_out_if;
    import glfs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [HIT_TILE_W-1:0] hit_tile;
    logic [HIT_X_W-1:0]    hit_x;
    logic [HIT_Y_W-1:0]    hit_y;
    logic [HIT_X_W-1:0]    free_x;
    logic [HIT_Y_W-1:0]    free_y;

    modport source (
        output valid, hit, hit_tile, hit_x, hit_y, free_x, free_y,
        input  ready
    );

    modport sink (
        input  valid, hit, hit_tile, hit_x, hit_y, free_x, free_y,
        output ready
    );
endinterface

// ===== rtl/grid_line_first_solid_scan_top.sv =====
// Top level of the tile map line scanner: map storage, setup sequencer and pixel walker.
//
// Usage: scan_in carries requests. command CMD_WRITE stores tile_value at
// (tile_col, tile_row), if inside the map, in the accepting cycle, with no result.
// command CMD_SCAN walks the line from start to end one pixel at a time and
// returns one result on scan_out: whether a solid tile (codes 1, 2, 5) was met,
// its code and pixel, and the last free pixel visited.
// A scan visits k pixels, where k is at most |dx| + |dy| + 1 in whole pixels
// (6143 for the default map). Setup runs operand prep, then two products on
// one shared multiplier, then the error term; the walker then issues one tile
// map read per cycle and checks each pixel in the cycle after its read is
// issued, on the registered RAM read.
// scan_in.ready is high only while the block is idle, so scans run one at a time.
// After reset the map is cleared one entry per cycle, all 2^(MAP_COLS_LOG2 +
// MAP_ROWS_LOG2) entries (32768 by default), with scan_in.ready low.
// The result sits in an output register; a stalled receiver holds it there,
// the block still accepts the next request, and a later scan waits for the
// register to drain before posting its result.
module grid_line_first_solid_scan_top #(
    parameter int MAP_COLS_LOG2    = 8,
    parameter int MAP_ROWS_LOG2    = 7,
    parameter int TILE_PIXELS_LOG2 = 4,
    parameter int FRACTION_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    glfs_in_if.sink           scan_in,
    glfs_out_if.source        scan_out
);
    import glfs_pkg::*;

    localparam int AW    = MAP_COLS_LOG2 + MAP_ROWS_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam int WAW   = AW + TILE_COL_W;
    localparam int PXW   = START_X_W - FRACTION_BITS;
    localparam int PYW   = START_Y_W - FRACTION_BITS;
    localparam int MXW   = MAP_COLS_LOG2 + TILE_PIXELS_LOG2;
    localparam int MYW   = MAP_ROWS_LOG2 + TILE_PIXELS_LOG2;
    localparam int PMAX1 = (PXW > PYW) ? PXW : PYW;
    localparam int PMAX2 = (MXW > MYW) ? MXW : MYW;
    localparam int PMAX  = (PMAX1 > PMAX2) ? PMAX1 : PMAX2;
    localparam int PW    = (PMAX + 3 > HIT_X_W + 1) ? PMAX + 3 : HIT_X_W + 1;
    localparam int CW    = PMAX1 + 1;
    localparam int FW    = FRACTION_BITS + 1;
    localparam int PRW   = FW + START_X_W;
    localparam int DW    = PRW + 1;
    localparam int TW    = START_X_W + 3;

    localparam logic [FW-1:0] ONE        = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [DW-1:0] FRAC_ROUND = DW'((1 << FRACTION_BITS) - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_MULA  = 3'd3;
    localparam logic [2:0] S_MULB  = 3'd4;
    localparam logic [2:0] S_TERM  = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // control
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic          iss_done_reg, iss_done_next;
    logic          out_valid_reg, out_valid_next;

    // request operands
    logic [START_X_W-1:0] sx_reg, ex_reg;
    logic [START_Y_W-1:0] sy_reg, ey_reg;

    // setup results
    logic                 dirx_reg, diry_reg, samecol_reg, samerow_reg;
    logic [FW-1:0]        fxq_reg, fyq_reg;
    logic [START_X_W-1:0] adx_reg;
    logic [START_Y_W-1:0] ady_reg;
    logic [PRW-1:0]       prod_reg, prod_a_reg;

    // walker
    logic [CW-1:0]      cnt_reg;
    logic [PW-1:0]      cur_x_reg, cur_y_reg;
    logic [TW-1:0]      term_reg;
    logic [HIT_X_W-1:0] chk_x_reg, free_x_reg;
    logic [HIT_Y_W-1:0] chk_y_reg, free_y_reg;
    logic               chk_in_reg, chk_last_reg;

    // result staging and output
    logic                  res_hit_reg, out_hit_reg;
    logic [HIT_TILE_W-1:0] res_tile_reg, out_tile_reg;
    logic [HIT_X_W-1:0]    res_hx_reg, res_fx_reg, out_hx_reg, out_fx_reg;
    logic [HIT_Y_W-1:0]    res_hy_reg, res_fy_reg, out_hy_reg, out_fy_reg;

    // tile map port
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [TILE_VALUE_W-1:0] ram_wdata, ram_rdata;

    logic          in_fire;
    logic          wr_in_map;
    logic [WAW-1:0] wr_wide;

    logic [PXW-1:0]       ix, ex_i, absnx;
    logic [PYW-1:0]       iy, ey_i, absny;
    logic                 dirx_c, diry_c;
    logic [FW-1:0]        fxq_c, fyq_c;
    logic [START_X_W-1:0] adx_c;
    logic [START_Y_W-1:0] ady_c;

    logic [FW-1:0]        mul_a;
    logic [START_X_W-1:0] mul_b;
    logic [PRW-1:0]       mul_p;

    logic [DW-1:0] diff, biased;
    logic [TW-1:0] term_init;

    logic          step_x;
    logic [TW-1:0] adx_ext, ady_ext;
    logic          pix_in_map;
    logic [AW-1:0] walk_addr;
    logic          chk_solid, stop, issue, out_free;

    glfs_ram #(
        .WIDTH (TILE_VALUE_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign scan_in.ready = (state_reg == S_IDLE);
    assign in_fire       = scan_in.valid && (state_reg == S_IDLE);

    assign wr_in_map = ((scan_in.tile_col >> MAP_COLS_LOG2) == '0)
                    && ((scan_in.tile_row >> MAP_ROWS_LOG2) == '0);
    assign wr_wide   = (WAW'(scan_in.tile_row) << MAP_COLS_LOG2) | WAW'(scan_in.tile_col);

    assign pix_in_map = !cur_x_reg[PW-1] && (cur_x_reg[PW-2:MXW] == '0)
                     && !cur_y_reg[PW-1] && (cur_y_reg[PW-2:MYW] == '0);
    assign walk_addr  = {cur_y_reg[MYW-1:TILE_PIXELS_LOG2], cur_x_reg[MXW-1:TILE_PIXELS_LOG2]};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = walk_addr;
        ram_wdata = scan_in.tile_value;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_IDLE)
        begin
            ram_we   = in_fire && (scan_in.command == CMD_WRITE) && wr_in_map;
            ram_addr = wr_wide[AW-1:0];
        end
    end

    // operand prep
    assign ix     = sx_reg[START_X_W-1:FRACTION_BITS];
    assign iy     = sy_reg[START_Y_W-1:FRACTION_BITS];
    assign ex_i   = ex_reg[START_X_W-1:FRACTION_BITS];
    assign ey_i   = ey_reg[START_Y_W-1:FRACTION_BITS];
    assign dirx_c = ex_i > ix;
    assign diry_c = ey_i > iy;
    assign absnx  = dirx_c ? ex_i - ix : ix - ex_i;
    assign absny  = diry_c ? ey_i - iy : iy - ey_i;
    assign fxq_c  = dirx_c ? ONE - FW'(sx_reg[FRACTION_BITS-1:0]) : FW'(sx_reg[FRACTION_BITS-1:0]);
    assign fyq_c  = diry_c ? ONE - FW'(sy_reg[FRACTION_BITS-1:0]) : FW'(sy_reg[FRACTION_BITS-1:0]);
    assign adx_c  = (ex_reg >= sx_reg) ? ex_reg - sx_reg : sx_reg - ex_reg;
    assign ady_c  = (ey_reg >= sy_reg) ? ey_reg - sy_reg : sy_reg - ey_reg;

    // shared multiplier
    assign mul_a = (state_reg == S_MULA) ? fyq_reg : fxq_reg;
    assign mul_b = (state_reg == S_MULA) ? adx_reg : START_X_W'(ady_reg);
    assign mul_p = PRW'(mul_a) * PRW'(mul_b);

    // error term, truncated toward zero
    assign diff      = {1'b0, prod_a_reg} - {1'b0, prod_reg};
    assign biased    = diff[DW-1] ? diff + FRAC_ROUND : diff;
    assign term_init = {{(TW - (DW - FRACTION_BITS)){biased[DW-1]}}, biased[DW-1:FRACTION_BITS]};

    // walker step
    assign step_x  = !term_reg[TW-1];
    assign adx_ext = TW'(adx_reg);
    assign ady_ext = TW'(ady_reg);

    assign chk_solid = chk_vld_reg && chk_in_reg && is_solid(ram_rdata);
    assign stop      = chk_vld_reg && (chk_solid || chk_last_reg);
    assign issue     = (state_reg == S_WALK) && !iss_done_reg && !stop;
    assign out_free  = !out_valid_reg || scan_out.ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        chk_vld_next   = 1'b0;
        iss_done_next  = iss_done_reg;
        out_valid_next = out_valid_reg && !scan_out.ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire && (scan_in.command == CMD_SCAN))
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MULA;
            end
            S_MULA:
            begin
                state_next = S_MULB;
            end
            S_MULB:
            begin
                state_next = S_TERM;
            end
            S_TERM:
            begin
                iss_done_next = 1'b0;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                chk_vld_next = issue;
                if (issue && (cnt_reg == '0))
                begin
                    iss_done_next = 1'b1;
                end
                if (stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            iss_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_vld_reg   <= chk_vld_next;
            iss_done_reg  <= iss_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sx_reg <= scan_in.start_x;
            sy_reg <= scan_in.start_y;
            ex_reg <= scan_in.end_x;
            ey_reg <= scan_in.end_y;
        end

        if (state_reg == S_PREP)
        begin
            dirx_reg    <= dirx_c;
            diry_reg    <= diry_c;
            samecol_reg <= (ex_i == ix);
            samerow_reg <= (ey_i == iy);
            fxq_reg     <= fxq_c;
            fyq_reg     <= fyq_c;
            adx_reg     <= (ex_i == ix) ? '0 : adx_c;
            ady_reg     <= ((ex_i != ix) && (ey_i == iy)) ? '0 : ady_c;
            cnt_reg     <= CW'(absnx) + CW'(absny);
            cur_x_reg   <= PW'(ix);
            cur_y_reg   <= PW'(iy);
        end

        if ((state_reg == S_MULA) || (state_reg == S_MULB))
        begin
            prod_reg   <= mul_p;
            prod_a_reg <= prod_reg;
        end

        if (state_reg == S_TERM)
        begin
            free_x_reg <= cur_x_reg[HIT_X_W-1:0];
            free_y_reg <= cur_y_reg[HIT_Y_W-1:0];
            if (samecol_reg)
            begin
                term_reg <= '1;
            end
            else if (samerow_reg)
            begin
                term_reg <= '0;
            end
            else
            begin
                term_reg <= term_init;
            end
        end

        if (issue)
        begin
            chk_x_reg    <= cur_x_reg[HIT_X_W-1:0];
            chk_y_reg    <= cur_y_reg[HIT_Y_W-1:0];
            chk_in_reg   <= pix_in_map;
            chk_last_reg <= (cnt_reg == '0);
            cnt_reg      <= cnt_reg - 1'b1;
            if (step_x)
            begin
                cur_x_reg <= dirx_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1;
                term_reg  <= term_reg - ady_ext;
            end
            else
            begin
                cur_y_reg <= diry_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1;
                term_reg  <= term_reg + adx_ext;
            end
        end

        if ((state_reg == S_WALK) && chk_vld_reg && !chk_solid)
        begin
            free_x_reg <= chk_x_reg;
            free_y_reg <= chk_y_reg;
        end

        if ((state_reg == S_WALK) && stop)
        begin
            res_hit_reg  <= chk_solid;
            res_tile_reg <= chk_solid ? ram_rdata : '0;
            res_hx_reg   <= chk_solid ? chk_x_reg : '0;
            res_hy_reg   <= chk_solid ? chk_y_reg : '0;
            res_fx_reg   <= chk_solid ? free_x_reg : chk_x_reg;
            res_fy_reg   <= chk_solid ? free_y_reg : chk_y_reg;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_hit_reg  <= res_hit_reg;
            out_tile_reg <= res_tile_reg;
            out_hx_reg   <= res_hx_reg;
            out_hy_reg   <= res_hy_reg;
            out_fx_reg   <= res_fx_reg;
            out_fy_reg   <= res_fy_reg;
        end
    end

    assign scan_out.valid    = out_valid_reg;
    assign scan_out.hit      = out_hit_reg;
    assign scan_out.hit_tile = out_tile_reg;
    assign scan_out.hit_x    = out_hx_reg;
    assign scan_out.hit_y    = out_hy_reg;
    assign scan_out.free_x   = out_fx_reg;
    assign scan_out.free_y   = out_fy_reg;

    a_chk_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == S_WALK))
        else $error("pixel check pending outside the walk");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(scan_out.valid) |-> ($past(state_reg) == S_DONE))
        else $error("result posted without a finished scan");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_out.valid && !scan_out.hit)
            |-> ((scan_out.hit_tile == '0) && (scan_out.hit_x == '0) && (scan_out.hit_y == '0)))
        else $error("miss result carries hit fields");

    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CLEAR) && (clr_reg == {AW{1'b1}})) |=> (state_reg == S_IDLE))
        else $error("map clear did not end in idle");

endmodule

// ===== rtl/glfs_ram.sv =====
// Generic single-port RAM with registered read data.
module glfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule
